@@ hw/rtl/fcac_pkg.sv @@
// Shared types and constants for the frame checker with additive checksum.
// Used by fcac_parser and frame_checker_additive_checksum_core; no dependencies.
`default_nettype none

package fcac_pkg;

    // Frame delimiters.
    localparam logic [7:0] HDR_FIRST  = 8'hA0;
    localparam logic [7:0] HDR_SECOND = 8'hA2;
    localparam logic [7:0] TRL_FIRST  = 8'hB0;
    localparam logic [7:0] TRL_SECOND = 8'hB3;

    // Payload bound and register widths.
    localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;
    localparam int unsigned CMD_W   = 8;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 9;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_COMMAND = 1'b0,
        CFG_PAYLOAD_SIZE     = 1'b1
    } t_cfg_index;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DELIM    = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_COMMAND  = 3'd3,
        ST_CHECKSUM = 3'd4
    } t_status;

    // Result kind.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // One result item from the parser.
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data_byte;
        t_status    status;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/fcac_parser.sv @@
// Frame parser: tracks position, running sum and error flags for one frame.
// Depends on fcac_pkg for delimiters, status codes and the result struct.
`default_nettype none

module fcac_parser #(
    parameter int unsigned MAX_PAYLOAD = fcac_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_restart,
    input  wire logic [fcac_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [fcac_pkg::SIZE_W-1:0]   i_size,
    output fcac_pkg::t_result                  o_result
);

    // The size register can never exceed its own range, so cap the bound there.
    localparam int unsigned SizeMax = (1 << fcac_pkg::SIZE_W) - 1;
    localparam int unsigned SizeCap = (MAX_PAYLOAD < SizeMax) ? MAX_PAYLOAD : SizeMax;
    localparam int unsigned PosW    = $clog2(SizeCap + 9);
    localparam logic [fcac_pkg::SIZE_W-1:0] SizeLimit = fcac_pkg::SIZE_W'(SizeCap);

    logic [PosW-1:0]              r_pos, n_pos;
    logic [fcac_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [7:0]                   r_len_high, n_len_high;
    logic [7:0]                   r_chk_high, n_chk_high;
    logic                         r_delim_bad, n_delim_bad;
    logic                         r_len_bad, n_len_bad;
    logic                         r_cmd_bad, n_cmd_bad;

    logic [fcac_pkg::SIZE_W-1:0]  size_eff;
    logic [PosW-1:0]              size_pos;
    logic [PosW-1:0]              cur_pos;
    logic [fcac_pkg::SUM_W-1:0]   cur_sum;
    logic [7:0]                   cur_len_high;
    logic [7:0]                   cur_chk_high;
    logic                         cur_delim, cur_len, cur_cmd;
    logic                         final_delim;

    // Clamp the configured size and extend it to the position width.
    assign size_eff = (i_size > SizeLimit) ? SizeLimit : i_size;
    assign size_pos = PosW'(size_eff);

    // A restart discards the frame in progress before this byte is handled.
    assign cur_pos      = i_restart ? '0 : r_pos;
    assign cur_sum      = i_restart ? '0 : r_sum;
    assign cur_len_high = i_restart ? '0 : r_len_high;
    assign cur_chk_high = i_restart ? '0 : r_chk_high;
    assign cur_delim    = i_restart ? 1'b0 : r_delim_bad;
    assign cur_len      = i_restart ? 1'b0 : r_len_bad;
    assign cur_cmd      = i_restart ? 1'b0 : r_cmd_bad;
    assign final_delim  = cur_delim | (i_byte != fcac_pkg::TRL_SECOND);

    // Per-byte frame decode and result selection.
    always_comb begin
        n_pos       = cur_pos + PosW'(1);
        n_sum       = cur_sum;
        n_len_high  = cur_len_high;
        n_chk_high  = cur_chk_high;
        n_delim_bad = cur_delim;
        n_len_bad   = cur_len;
        n_cmd_bad   = cur_cmd;
        o_result    = '{valid: 1'b0, kind: fcac_pkg::KIND_PAYLOAD, data_byte: 8'd0,
                        status: fcac_pkg::ST_OK, last: 1'b0};

        if (cur_pos >= size_pos + PosW'(8)) begin
            // Final trailer byte: report the status and close the frame.
            o_result.valid = 1'b1;
            o_result.kind  = fcac_pkg::KIND_STATUS;
            o_result.last  = 1'b1;
            if (final_delim) begin
                o_result.status = fcac_pkg::ST_DELIM;
            end else if (cur_len) begin
                o_result.status = fcac_pkg::ST_LENGTH;
            end else if (cur_cmd) begin
                o_result.status = fcac_pkg::ST_COMMAND;
            end else if (cur_sum != '0) begin
                o_result.status = fcac_pkg::ST_CHECKSUM;
            end else begin
                o_result.status = fcac_pkg::ST_OK;
            end
            n_pos       = '0;
            n_sum       = '0;
            n_len_high  = '0;
            n_chk_high  = '0;
            n_delim_bad = 1'b0;
            n_len_bad   = 1'b0;
            n_cmd_bad   = 1'b0;
        end else if (cur_pos == PosW'(0)) begin
            n_delim_bad = cur_delim | (i_byte != fcac_pkg::HDR_FIRST);
        end else if (cur_pos == PosW'(1)) begin
            n_delim_bad = cur_delim | (i_byte != fcac_pkg::HDR_SECOND);
        end else if (cur_pos == PosW'(2)) begin
            n_len_high = i_byte;
        end else if (cur_pos == PosW'(3)) begin
            n_len_bad = cur_len |
                ({cur_len_high, i_byte} != (fcac_pkg::SUM_W'(size_eff) + 16'd1));
        end else if (cur_pos == PosW'(4)) begin
            n_cmd_bad = cur_cmd | (i_byte != i_cmd);
            n_sum     = fcac_pkg::SUM_W'(i_byte);
        end else if (cur_pos < size_pos + PosW'(5)) begin
            // Payload byte: accumulate and pass it on.
            n_sum              = cur_sum + fcac_pkg::SUM_W'(i_byte);
            o_result.valid     = 1'b1;
            o_result.data_byte = i_byte;
        end else if (cur_pos == size_pos + PosW'(5)) begin
            n_chk_high = i_byte;
        end else if (cur_pos == size_pos + PosW'(6)) begin
            // Zero after this XOR means the checksum matched.
            n_sum = cur_sum ^ {cur_chk_high, i_byte};
        end else begin
            n_delim_bad = cur_delim | (i_byte != fcac_pkg::TRL_FIRST);
        end
    end

    // Frame control state, including the captured high bytes of the 16-bit fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_len_high  <= '0;
            r_chk_high  <= '0;
            r_delim_bad <= 1'b0;
            r_len_bad   <= 1'b0;
            r_cmd_bad   <= 1'b0;
        end else if (i_fire) begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_len_high  <= n_len_high;
            r_chk_high  <= n_chk_high;
            r_delim_bad <= n_delim_bad;
            r_len_bad   <= n_len_bad;
            r_cmd_bad   <= n_cmd_bad;
        end
    end

`ifndef NO_ASSERTIONS
    // A status transfer always returns the parser to the start of a frame.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.valid && o_result.last |=> r_pos == '0 && r_sum == '0)
        else $error("parser state not cleared after frame status");

    // Position never runs past the final trailer position.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosW'(SizeCap + 8))
        else $error("frame position out of range");

    // Error flags only become set while bytes are being consumed.
    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_fire) && $past(i_rst_n) |-> $stable(r_delim_bad) && $stable(r_len_bad)
            && $stable(r_cmd_bad) && $stable(r_pos))
        else $error("parser state moved without an input byte");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/frame_checker_additive_checksum_core.sv @@
// Top level of the reply frame checker: stream ports, config registers, pipeline.
// Depends on fcac_pkg and fcac_parser.
`default_nettype none

// Receives a reply frame one byte per transfer (A0 A2, big-endian length =
// payload size + 1, command, payload, big-endian 16-bit sum of command and
// payload, B0 B3). Payload bytes come out as they arrive with tuser low; after
// the final trailer byte one transfer with tuser and tlast high carries the
// frame status (0 ok, 1 header/trailer, 2 length, 3 command, 4 checksum).
// Setting the input tuser restarts the frame on that byte. The block takes one
// byte per clock while the output is not held back: each byte passes an input
// register, a combinational compare and 16-bit add in the parser, and lands in
// the output register. Input stalls come only from a result waiting on
// m_axis_tready. Write the configuration only while no frame byte is in
// flight.
module frame_checker_additive_checksum_core #(
    parameter int unsigned MAX_PAYLOAD = fcac_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [fcac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fcac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                                s_axis_tuser,  // [0] restart
    // Output stream.
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [15:0]                         m_axis_tdata,  // [7:0] data_byte,
                                                                    // [10:8] frame_status
    output      logic                                m_axis_tuser,  // [0] kind
    output      logic                                m_axis_tlast
);

    logic [fcac_pkg::CMD_W-1:0]  r_expected_command;
    logic [fcac_pkg::SIZE_W-1:0] r_payload_size;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;

    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_byte;
    logic [2:0] r_out_status;
    logic       r_out_last;

    logic              out_free;
    logic              fire;
    logic              in_take;
    fcac_pkg::t_result result;

    // Configuration register decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= '0;
            r_payload_size     <= '0;
        end else if (i_cfg_we) begin
            unique case (fcac_pkg::t_cfg_index'(i_cfg_index))
                fcac_pkg::CFG_EXPECTED_COMMAND: begin
                    r_expected_command <= i_cfg_data[fcac_pkg::CMD_W-1:0];
                end
                fcac_pkg::CFG_PAYLOAD_SIZE: begin
                    r_payload_size <= i_cfg_data[fcac_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The parser consumes the held byte when the output register can take a result.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
    end

    fcac_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .i_cmd     (r_expected_command),
        .i_size    (r_payload_size),
        .o_result  (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_out_kind   <= result.kind;
            r_out_byte   <= result.data_byte;
            r_out_status <= result.status;
            r_out_last   <= result.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_status, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // A held input byte stays held until the parser consumes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_restart))
        else $error("held input byte lost before processing");

    // Only the status transfer ends a frame.
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == fcac_pkg::KIND_STATUS)
        else $error("tlast on a payload transfer");

    // Payload transfers carry an ok status, status transfers a zero data byte.
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == fcac_pkg::KIND_PAYLOAD && m_axis_tdata[15:8] == 8'd0)
            || (m_axis_tuser == fcac_pkg::KIND_STATUS && m_axis_tdata[7:0] == 8'd0
                && m_axis_tdata[15:11] == 5'd0))
        else $error("unused output field not zero");

    // A result is never produced without a consumed byte behind it.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(fire))
        else $error("output transfer without a processed byte");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for frame_checker_additive_checksum_core.
// Depends on fcac_pkg and the core RTL; holds its own frame predictor,
// a stream driver, a result monitor and the stimulus sequence.
`default_nettype none

module tb_top;
    import fcac_pkg::*;

    localparam int unsigned FRAME_MAX    = MAX_PAYLOAD_DEFAULT;
    localparam int unsigned RANDOM_BYTES = 1650;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned BURST_FIRST  = 700;
    localparam int unsigned BURST_LAST   = 1000;

    // Fault injection bits for generated frames.
    localparam logic [4:0] FLT_HEADER   = 5'b00001;
    localparam logic [4:0] FLT_LENGTH   = 5'b00010;
    localparam logic [4:0] FLT_COMMAND  = 5'b00100;
    localparam logic [4:0] FLT_CHECKSUM = 5'b01000;
    localparam logic [4:0] FLT_TRAILER  = 5'b10000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_rx_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        t_status    status;
        logic       last;
    } t_frame_result;

    // Clock, reset and DUT ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_index  i_cfg_index = CFG_EXPECTED_COMMAND;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0; // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] data_byte, [10:8] frame_status
    logic        m_axis_tuser;        // [0] kind
    logic        m_axis_tlast;

    // Bench bookkeeping.
    t_rx_item        rx_bytes_pending[$];
    t_frame_result   frame_results_due[$];
    int unsigned     bytes_queued = 0;
    int unsigned     bytes_accepted = 0;
    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;
    int unsigned     hold_left = 0;
    logic            hold_done = 1'b0;

    // Predictor copy of the registers and the frame state.
    logic [7:0]  cfg_command = '0;
    logic [8:0]  cfg_size = '0;
    logic [8:0]  fr_pos = '0;
    logic [15:0] fr_sum = '0;
    logic [7:0]  fr_len_hi = '0;
    logic [7:0]  fr_cks_hi = '0;
    logic        fr_delim_bad = 1'b0;
    logic        fr_len_bad = 1'b0;
    logic        fr_cmd_bad = 1'b0;

    frame_checker_additive_checksum_core #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Payload size as the block sees it, clipped to the build bound.
    function automatic int unsigned effective_size();
        return (cfg_size > FRAME_MAX) ? FRAME_MAX : int'(cfg_size);
    endfunction

    function automatic void clear_frame_state();
        fr_pos = '0;
        fr_sum = '0;
        fr_len_hi = '0;
        fr_cks_hi = '0;
        fr_delim_bad = 1'b0;
        fr_len_bad = 1'b0;
        fr_cmd_bad = 1'b0;
    endfunction

    // Advance the frame state by one accepted byte and queue any result it causes.
    function automatic void predict_frame_byte(logic [7:0] rx, logic restart);
        int unsigned size_eff;
        int unsigned pos;
        t_status     st;
        size_eff = effective_size();
        if (restart)
            clear_frame_state();
        pos = fr_pos;

        // Any byte at or past the final slot closes the frame with a status.
        if (pos >= size_eff + 8) begin
            if (rx != TRL_SECOND)
                fr_delim_bad = 1'b1;
            if (fr_delim_bad)
                st = ST_DELIM;
            else if (fr_len_bad)
                st = ST_LENGTH;
            else if (fr_cmd_bad)
                st = ST_COMMAND;
            else if (fr_sum != 16'h0000)
                st = ST_CHECKSUM;
            else
                st = ST_OK;
            frame_results_due.push_back('{kind: KIND_STATUS, data_byte: 8'h00,
                                          status: st, last: 1'b1});
            clear_frame_state();
            return;
        end

        fr_pos = 9'(pos + 1);
        if (pos == 0) begin
            if (rx != HDR_FIRST)
                fr_delim_bad = 1'b1;
        end else if (pos == 1) begin
            if (rx != HDR_SECOND)
                fr_delim_bad = 1'b1;
        end else if (pos == 2) begin
            fr_len_hi = rx;
        end else if (pos == 3) begin
            if ({fr_len_hi, rx} != 16'(size_eff + 1))
                fr_len_bad = 1'b1;
        end else if (pos == 4) begin
            if (rx != cfg_command)
                fr_cmd_bad = 1'b1;
            fr_sum = {8'h00, rx};
        end else if (pos < size_eff + 5) begin
            fr_sum = fr_sum + {8'h00, rx};
            frame_results_due.push_back('{kind: KIND_PAYLOAD, data_byte: rx,
                                          status: ST_OK, last: 1'b0});
        end else if (pos == size_eff + 5) begin
            fr_cks_hi = rx;
        end else if (pos == size_eff + 6) begin
            // A matching checksum leaves zero behind.
            fr_sum = fr_sum ^ {fr_cks_hi, rx};
        end else begin
            if (rx != TRL_FIRST)
                fr_delim_bad = 1'b1;
        end
    endfunction

    // Random idle decision shared by both stream sides; off inside the burst window.
    function automatic logic take_break();
        if (bytes_accepted >= BURST_FIRST && bytes_accepted < BURST_LAST)
            return 1'b0;
        return $urandom_range(0, 99) < 34;
    endfunction

    // Input driver: predicts on every accepted transfer, then offers the next byte.
    always @(posedge i_clk) begin
        t_rx_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_frame_byte(s_axis_tdata, s_axis_tuser);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_bytes_pending.size() != 0 && !take_break()) begin
                    item = rx_bytes_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.rx_byte;
                    s_axis_tuser  <= item.restart;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each transfer and throttles the ready line.
    always @(posedge i_clk) begin
        t_frame_result due;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected result: kind=%0b byte=%02h status=%0d last=%0b",
                             $time, m_axis_tuser, m_axis_tdata[7:0],
                             m_axis_tdata[10:8], m_axis_tlast);
                    error_count <= error_count + 1;
                end else begin
                    due = frame_results_due.pop_front();
                    if (m_axis_tuser !== due.kind || m_axis_tdata[7:0] !== due.data_byte ||
                        m_axis_tdata[10:8] !== due.status || m_axis_tlast !== due.last) begin
                        $display({"%0t: result mismatch: expected kind=%0b byte=%02h ",
                                  "status=%0d last=%0b, actual kind=%0b byte=%02h ",
                                  "status=%0d last=%0b"},
                                 $time, due.kind, due.data_byte, due.status, due.last,
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                                 m_axis_tlast);
                        error_count <= error_count + 1;
                    end
                end
            end

            // One long hold-off while bytes are still waiting lets the block back up.
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && bytes_accepted >= HOLD_AT &&
                         rx_bytes_pending.size() != 0) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !take_break();
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] rx, input logic restart);
        rx_bytes_pending.push_back('{rx_byte: rx, restart: restart});
        bytes_queued++;
    endtask

    // Wait until every byte is taken and every result is back, then let the pipe settle.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (rx_bytes_pending.size() != 0 || s_axis_tvalid ||
               frame_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index index, input logic [8:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == CFG_EXPECTED_COMMAND)
            cfg_command = value[7:0];
        else
            cfg_size = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Build one frame for the current settings, with optional faults and truncation.
    task automatic queue_frame(input logic first_restart, input logic [4:0] faults,
                               input int unsigned cut_at);
        logic [7:0]  frame_bytes[$];
        logic [15:0] length_word;
        logic [15:0] sum_word;
        logic [7:0]  cmd_byte;
        logic [7:0]  pay;
        int unsigned size_eff;
        int unsigned fill_mode;
        int unsigned count;
        size_eff = effective_size();
        length_word = 16'(size_eff + 1);
        if (faults & FLT_LENGTH)
            length_word ^= 16'($urandom_range(1, 65535));
        cmd_byte = cfg_command;
        if (faults & FLT_COMMAND)
            cmd_byte ^= 8'($urandom_range(1, 255));
        frame_bytes = '{HDR_FIRST, HDR_SECOND, length_word[15:8], length_word[7:0], cmd_byte};
        sum_word = {8'h00, cmd_byte};

        // Payload is mostly random, sometimes all ones or all zeros.
        fill_mode = $urandom_range(0, 7);
        for (int unsigned n = 0; n < size_eff; n++) begin
            pay = (fill_mode == 0) ? 8'hFF : (fill_mode == 1) ? 8'h00 : 8'($urandom);
            frame_bytes.push_back(pay);
            sum_word += {8'h00, pay};
        end
        if (faults & FLT_CHECKSUM)
            sum_word ^= 16'($urandom_range(1, 65535));
        frame_bytes.push_back(sum_word[15:8]);
        frame_bytes.push_back(sum_word[7:0]);
        frame_bytes.push_back(TRL_FIRST);
        frame_bytes.push_back(TRL_SECOND);
        if (faults & FLT_HEADER)
            frame_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        if (faults & FLT_TRAILER)
            frame_bytes[size_eff + 7 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));

        count = (cut_at != 0) ? cut_at : frame_bytes.size();
        for (int unsigned n = 0; n < count; n++)
            queue_byte(frame_bytes[n], (n == 0) ? first_restart : 1'b0);
    endtask

    // Stimulus: reset, directed frames, then randomized phases.
    initial begin
        logic [7:0]  opening[9];
        logic [7:0]  closing[9];
        int unsigned random_start;
        int unsigned phase;
        int unsigned frames;
        int unsigned pick;
        int unsigned size_value;
        logic [7:0]  cmd_value;
        logic [4:0]  faults;
        logic        need_restart;
        logic        first_restart;

        opening = '{8'hA0, 8'hA2, 8'h00, 8'h05, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
        closing = '{8'hA0, 8'hA2, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'hB0, 8'hB3};
        clear_frame_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Four-byte payload frame stopped right before its checksum.
        write_register(CFG_PAYLOAD_SIZE, 9'd4);
        write_register(CFG_EXPECTED_COMMAND, 9'h0FF);
        foreach (opening[n])
            queue_byte(opening[n], 1'b0);
        wait_idle();

        // Shrinking the size mid-frame turns the next byte into the final one.
        write_register(CFG_PAYLOAD_SIZE, 9'd0);
        queue_byte(TRL_SECOND, 1'b0);
        // Abandoned frame, then a clean empty-payload frame started by restart.
        queue_byte(HDR_FIRST, 1'b1);
        queue_byte(8'h12, 1'b0);
        foreach (closing[n])
            queue_byte(closing[n], n == 0);
        wait_idle();

        // Random phases: new settings each phase, then a mix of clean, faulted and truncated frames and stray bytes.
        random_start = bytes_queued;
        phase = 0;
        need_restart = 1'b0;
        while (bytes_queued - random_start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (phase == 0)
                size_value = 511;
            else if (phase == 1)
                size_value = FRAME_MAX;
            else if (pick < 7)
                size_value = $urandom_range(0, 6);
            else if (pick < 9)
                size_value = $urandom_range(7, 20);
            else
                size_value = $urandom_range(255, 300);
            pick = $urandom_range(0, 7);
            cmd_value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            write_register(CFG_EXPECTED_COMMAND, {1'($urandom), cmd_value});
            write_register(CFG_PAYLOAD_SIZE, 9'(size_value));

            frames = (effective_size() >= 64) ? $urandom_range(1, 2) : $urandom_range(2, 10);
            repeat (frames) begin
                first_restart = need_restart ? ($urandom_range(0, 9) < 8)
                                             : ($urandom_range(0, 3) == 0);
                need_restart = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    faults = ($urandom_range(0, 99) < 60) ? 5'b0
                                                          : 5'($urandom_range(1, 31));
                    queue_frame(first_restart, faults, 0);
                end else if (pick < 85) begin
                    queue_frame(first_restart, 5'b0,
                                $urandom_range(1, effective_size() + 8));
                    need_restart = 1'b1;
                end else begin
                    repeat ($urandom_range(1, 4))
                        queue_byte(8'($urandom), 1'($urandom));
                    need_restart = 1'b1;
                end
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
